// ===== sv/multitap_keypad_event_encoder_assert.svh =====
// Assertion macros shared by the keypad event encoder modules.
`ifndef MULTITAP_KEYPAD_EVENT_ENCODER_ASSERT_SVH
`define MULTITAP_KEYPAD_EVENT_ENCODER_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define MTKE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mtke: assertion failed");

// Next-cycle implication, checked on i_clk outside reset.
`define MTKE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mtke: assertion failed");

`endif

// ===== sv/mtke_pkg.sv =====
// Types, constants and tables for the multi-tap keypad event encoder.
package mtke_pkg;

    // Event kinds carried in each output word.
    typedef enum logic [3:0] {
        EV_CHAR       = 4'd0,
        EV_BACK       = 4'd1,
        EV_SELECT     = 4'd2,
        EV_LEFT       = 4'd3,
        EV_RIGHT      = 4'd4,
        EV_ALERT      = 4'd5,
        EV_DISMISS    = 4'd6,
        EV_MENU_OPEN  = 4'd7,
        EV_MENU_CLOSE = 4'd8,
        EV_PALETTE    = 4'd9
    } t_event_kind;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index CFG_LONG_PRESS = 2'd0;
    localparam t_cfg_index CFG_TAP_WINDOW = 2'd1;

    localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;
    localparam logic [15:0] TAP_WINDOW_RESET = 16'd500;

    // Defaults for the top-level parameters.
    localparam int SEQUENCE_LENGTH_DEF = 10;
    localparam int PALETTE_COUNT_DEF   = 7;
    localparam int QUEUE_DEPTH_DEF     = 2;

    // Key layout and special masks.
    localparam logic [3:0]  DIGIT_KEYS      = 4'd12;
    localparam logic [3:0]  KEY_UP          = 4'd12;
    localparam logic [3:0]  KEY_RIGHT       = 4'd13;
    localparam logic [3:0]  KEY_DOWN        = 4'd14;
    localparam logic [15:0] LONG_PRESS_MASK = 16'h0001;
    localparam logic [15:0] MENU_STEP_MASK  = 16'h0800;
    localparam logic [15:0] MENU_CLOSE_MASK = 16'h0400;
    localparam logic [7:0]  BACKSPACE_CHAR  = 8'h08;
    localparam logic [2:0]  TAP_LAST_SLOT   = 3'd5;

    // Expected single-button word for each step of the hidden sequence.
    localparam logic [15:0] SEQ_TABLE [16] = '{
        16'h1000, 16'h1000, 16'h4000, 16'h4000, 16'h8000, 16'h2000, 16'h8000, 16'h2000,
        16'h0400, 16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    // Letters of each digit key; a zero slot ends the cycle.
    localparam logic [7:0] LETTERS [12][6] = '{
        '{8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h20, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h23, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h78, 8'h79, 8'h7A, 8'h39, 8'h00},
        '{8'h74, 8'h75, 8'h76, 8'h38, 8'h00, 8'h00},
        '{8'h70, 8'h71, 8'h72, 8'h73, 8'h37, 8'h00},
        '{8'h6D, 8'h6E, 8'h6F, 8'h36, 8'h00, 8'h00},
        '{8'h6A, 8'h6B, 8'h6C, 8'h35, 8'h00, 8'h00},
        '{8'h67, 8'h68, 8'h69, 8'h34, 8'h00, 8'h00},
        '{8'h64, 8'h65, 8'h66, 8'h33, 8'h00, 8'h00},
        '{8'h61, 8'h62, 8'h63, 8'h32, 8'h00, 8'h00},
        '{8'h2E, 8'h2C, 8'h3F, 8'h21, 8'h2B, 8'h31}
    };

    // Input word: one poll sample.
    typedef struct packed {
        logic [15:0] button_mask;
        logic [31:0] now_ms;
    } t_in_word;

    // Output word: one event.
    typedef struct packed {
        logic [3:0] event_kind;
        logic [7:0] key_char;
        logic [2:0] palette_index;
        logic       last_of_run;
    } t_out_word;

    // Job handed from the classifier to the event emitter.
    typedef struct packed {
        t_event_kind lead_a;
        t_event_kind lead_b;
        logic [1:0]  lead_count;
        logic [15:0] keys;
        logic        tap_ok;
        logic [2:0]  palette;
    } t_job;

endpackage

// ===== sv/multitap_keypad_event_encoder.sv =====
// Top level of the multi-tap keypad event encoder.
//
// Input channel: one word per poll sample (button mask and millisecond time),
// taken on a clock edge where i_in_valid is high and o_in_stall is low.
// Output channel: one word per event, taken where o_out_valid is high and
// i_out_stall is low; last_of_run marks the final word of a sample.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 long-press time, 1 tap window); other indexes are ignored.
// A taken sample's job is written into the job queue, and the emitter
// registers its event words. Throughput: one event word per cycle while the
// receiver does not stall; a sample causes at most 17 events, and one that
// causes none pushes no job. A job queue lets new samples be classified while
// earlier events still drain; o_in_stall rises only when that queue is full.
// When the receiver stalls, the output word holds and the emitter pauses.
// Reset (synchronous, active low) clears all keypad state and the queue and
// restores the default long-press and tap-window times.
module multitap_keypad_event_encoder import mtke_pkg::*; #(
    parameter int SEQUENCE_LENGTH = SEQUENCE_LENGTH_DEF,
    parameter int PALETTE_COUNT   = PALETTE_COUNT_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_index  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    logic push, full, pop, head_valid;
    t_job job, head;

    assign o_in_stall = full;

    // Classifier.
    mtke_front #(
        .SEQUENCE_LENGTH(SEQUENCE_LENGTH),
        .PALETTE_COUNT  (PALETTE_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_queue_full(full),
        .o_push      (push),
        .o_job       (job)
    );

    // Job queue.
    mtke_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_job       (job),
        .o_full      (full),
        .i_pop       (pop),
        .o_head_valid(head_valid),
        .o_head      (head)
    );

    // Event emitter.
    mtke_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(head_valid),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== sv/mtke_front.sv =====
// Sample classifier: config registers, edge detection, sequence and menu state.
module mtke_front import mtke_pkg::*; #(
    parameter int SEQUENCE_LENGTH = SEQUENCE_LENGTH_DEF,
    parameter int PALETTE_COUNT   = PALETTE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_index  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  t_in_word    i_in_word,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [15:0] r_long_press, r_tap_window, r_prev, n_prev;
    logic [3:0]  r_seq_pos, n_seq_pos;
    logic        r_alert, n_alert, r_menu, n_menu;
    logic [31:0] r_last_press, n_last_press;
    logic [2:0]  r_palette, n_palette;

    logic        in_fire;
    logic [15:0] mask, fresh;
    logic [31:0] elapsed;
    logic [4:0]  seq_inc;
    logic [3:0]  pal_inc;
    t_job        job;

    assign in_fire = i_in_valid && !i_queue_full;
    assign mask    = i_in_word.button_mask;
    assign fresh   = mask & ~r_prev;
    assign elapsed = i_in_word.now_ms - r_last_press;
    assign seq_inc = {1'b0, r_seq_pos} + 5'd1;
    assign pal_inc = {1'b0, r_palette} + 4'd1;

    // Classify the sample and build the job for the emitter.
    always_comb begin
        n_prev       = r_prev;
        n_seq_pos    = r_seq_pos;
        n_alert      = r_alert;
        n_menu       = r_menu;
        n_last_press = r_last_press;
        n_palette    = r_palette;
        job          = '{lead_a: EV_CHAR, lead_b: EV_CHAR, lead_count: 2'd0,
                         keys: 16'h0000, tap_ok: 1'b0, palette: 3'd0};
        if (mask == 16'h0000) begin
            n_prev = 16'h0000;
        end else if (fresh == 16'h0000) begin
            n_prev = mask;
            if (mask == LONG_PRESS_MASK && elapsed > {16'h0000, r_long_press} && !r_menu) begin
                n_menu         = 1'b1;
                job.lead_a     = EV_BACK;
                job.lead_b     = EV_MENU_OPEN;
                job.lead_count = 2'd2;
            end
        end else if (r_alert) begin
            // The dismissing press leaves the stored mask alone.
            n_alert        = 1'b0;
            job.lead_a     = EV_DISMISS;
            job.lead_count = 2'd1;
        end else begin
            n_prev = mask;
            if (fresh == SEQ_TABLE[r_seq_pos]) begin
                if (seq_inc >= 5'(SEQUENCE_LENGTH)) begin
                    n_seq_pos      = 4'd0;
                    n_alert        = 1'b1;
                    job.lead_a     = EV_ALERT;
                    job.lead_count = 2'd1;
                end else begin
                    n_seq_pos = seq_inc[3:0];
                end
            end else begin
                n_seq_pos = 4'd0;
            end
            if (r_menu) begin
                if (fresh == MENU_STEP_MASK) begin
                    n_palette = (pal_inc == 4'(PALETTE_COUNT)) ? 3'd0 : pal_inc[2:0];
                    if (job.lead_count == 2'd0) begin
                        job.lead_a = EV_PALETTE;
                    end else begin
                        job.lead_b = EV_PALETTE;
                    end
                    job.lead_count = job.lead_count + 2'd1;
                end else if (fresh == MENU_CLOSE_MASK) begin
                    n_menu = 1'b0;
                    if (job.lead_count == 2'd0) begin
                        job.lead_a = EV_MENU_CLOSE;
                    end else begin
                        job.lead_b = EV_MENU_CLOSE;
                    end
                    job.lead_count = job.lead_count + 2'd1;
                end
            end else begin
                job.keys     = fresh;
                job.tap_ok   = elapsed < {16'h0000, r_tap_window};
                n_last_press = i_in_word.now_ms;
            end
        end
        job.palette = n_palette;
    end

    assign o_push = in_fire && (job.lead_count != 2'd0 || job.keys != 16'h0000);
    assign o_job  = job;

    // Configuration and classifier state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= LONG_PRESS_RESET;
            r_tap_window <= TAP_WINDOW_RESET;
            r_prev       <= 16'h0000;
            r_seq_pos    <= 4'd0;
            r_alert      <= 1'b0;
            r_menu       <= 1'b0;
            r_last_press <= 32'd0;
            r_palette    <= 3'd0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_LONG_PRESS) begin
                r_long_press <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_TAP_WINDOW) begin
                r_tap_window <= i_cfg_data;
            end
            if (in_fire) begin
                r_prev       <= n_prev;
                r_seq_pos    <= n_seq_pos;
                r_alert      <= n_alert;
                r_menu       <= n_menu;
                r_last_press <= n_last_press;
                r_palette    <= n_palette;
            end
        end
    end

endmodule

// ===== sv/mtke_queue.sv =====
// Short job queue between the classifier and the emitter.
`include "multitap_keypad_event_encoder_assert.svh"
module mtke_queue import mtke_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `MTKE_ASSERT_IMPLY(a_no_push_when_full, i_push, !o_full)
    `MTKE_ASSERT_IMPLY(a_no_pop_when_empty, i_pop, r_count != '0)

endmodule

// ===== sv/mtke_back.sv =====
// Event emitter: walks each job one word per cycle unless stalled, with multi-tap letter state.
`include "multitap_keypad_event_encoder_assert.svh"
module mtke_back import mtke_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_job      i_head,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    logic        r_started, r_char_pend;
    logic [15:0] r_keys, n_keys;
    logic [1:0]  r_lead_left, n_lead_left;
    logic [7:0]  r_pend_char, n_pend_char;
    logic [3:0]  r_last_key, n_last_key;
    logic [2:0]  r_tap_pos, n_tap_pos;
    logic        n_char_pend;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        step, last, tap_back;
    logic [15:0] cur_keys;
    logic [1:0]  cur_lead;
    logic [3:0]  bit_idx;
    logic [2:0]  tp_inc;
    t_event_kind ev_kind, lead_kind;
    logic [7:0]  ev_char;

    assign step     = i_head_valid && (!r_out_valid || !i_out_stall);
    assign cur_keys = r_started ? r_keys : i_head.keys;
    assign cur_lead = r_started ? r_lead_left : i_head.lead_count;
    assign tp_inc   = (r_tap_pos == TAP_LAST_SLOT) ? 3'd0 : r_tap_pos + 3'd1;

    // Lowest pending key.
    always_comb begin
        bit_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (cur_keys[k]) begin
                bit_idx = 4'(k);
            end
        end
    end

    // Choose the next event word and the progress through the job.
    always_comb begin
        n_keys      = cur_keys;
        n_lead_left = cur_lead;
        n_pend_char = r_pend_char;
        n_char_pend = 1'b0;
        n_last_key  = r_last_key;
        n_tap_pos   = r_tap_pos;
        ev_kind     = EV_CHAR;
        ev_char     = 8'h00;
        last        = 1'b0;
        tap_back    = 1'b0;
        lead_kind   = (cur_lead == i_head.lead_count) ? i_head.lead_a : i_head.lead_b;
        if (r_char_pend) begin
            // Second half of a repeated tap.
            ev_char = r_pend_char;
            last    = (cur_keys == 16'h0000);
        end else if (cur_lead != 2'd0) begin
            ev_kind     = lead_kind;
            ev_char     = (lead_kind == EV_BACK) ? BACKSPACE_CHAR : 8'h00;
            n_lead_left = cur_lead - 2'd1;
            last        = (cur_lead == 2'd1) && (cur_keys == 16'h0000);
        end else begin
            n_keys     = cur_keys & ~(16'h0001 << bit_idx);
            n_last_key = bit_idx;
            last       = (n_keys == 16'h0000);
            if (bit_idx < DIGIT_KEYS) begin
                if (bit_idx == r_last_key && i_head.tap_ok) begin
                    n_tap_pos   = (LETTERS[bit_idx][tp_inc] == 8'h00) ? 3'd0 : tp_inc;
                    n_pend_char = LETTERS[bit_idx][n_tap_pos];
                    n_char_pend = 1'b1;
                    tap_back    = 1'b1;
                    ev_kind     = EV_BACK;
                    ev_char     = BACKSPACE_CHAR;
                    last        = 1'b0;
                end else begin
                    n_tap_pos = 3'd0;
                    ev_char   = LETTERS[bit_idx][0];
                end
            end else if (bit_idx == KEY_DOWN) begin
                ev_kind = EV_BACK;
                ev_char = BACKSPACE_CHAR;
            end else if (bit_idx == KEY_UP) begin
                ev_kind = EV_SELECT;
            end else if (bit_idx == KEY_RIGHT) begin
                ev_kind = EV_RIGHT;
            end else begin
                ev_kind = EV_LEFT;
            end
        end
    end

    assign o_pop       = step && last;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Job progress and multi-tap state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_char_pend <= 1'b0;
            r_keys      <= 16'h0000;
            r_lead_left <= 2'd0;
            r_last_key  <= 4'd0;
            r_tap_pos   <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_started   <= !last;
                r_char_pend <= n_char_pend;
                r_keys      <= n_keys;
                r_lead_left <= n_lead_left;
                r_last_key  <= n_last_key;
                r_tap_pos   <= n_tap_pos;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word and pending letter.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_pend_char <= n_pend_char;
            r_out_word  <= '{event_kind: ev_kind, key_char: ev_char,
                             palette_index: i_head.palette, last_of_run: last};
        end
    end

    `MTKE_ASSERT_IMPLY(a_pending_char_has_job, r_char_pend, i_head_valid && r_started)
    `MTKE_ASSERT_IMPLY(a_scan_not_empty, step && !r_char_pend && cur_lead == 2'd0,
                       cur_keys != 16'h0000)
    `MTKE_ASSERT_NEXT(a_tap_back_then_char, step && tap_back, r_char_pend)

endmodule
